[design/pftd_pkg.sv]
// shared types and constants for the trial-division prime filter
// no dependencies; used by pftd_ctrl, pftd_datapath and prime_filter_trial_division
package pftd_pkg;

	// fixed port widths
	localparam int NUM_W  = 16;
	localparam int SLOT_W = 7;

	// defaults for the top-level parameters
	localparam int VALUE_WIDTH_DEF = 16;
	localparam int DEST_DEPTH_DEF  = 128;

	// first trial divisor
	localparam int FIRST_DIVISOR = 2;

	// commands from controller to datapath
	typedef struct packed {
		logic load;       // take a new input word
		logic start_div;  // begin a remainder for the current divisor
		logic div_step;   // one restoring-division bit
		logic next_div;   // advance to the next divisor
		logic emit;       // load the output register, bump the count (a clear on finish wins)
		logic finish;     // end of item: clear count after last of set
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic n_small;    // value below the first divisor
		logic full;       // destination list full
		logic sq_gt_n;    // divisor squared exceeds the value
		logic last_bit;   // final division bit this cycle
		logic rem_zero;   // remainder is zero
		logic out_free;   // output register can take a word
	} sts_t;

endpackage

[design/pftd_ctrl.sv]
// controller state machine for the trial-division prime filter
// depends on pftd_pkg for the command and status structs
module pftd_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  pftd_pkg::sts_t sts,
	output pftd_pkg::cmd_t cmd
);
	import pftd_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_CHECK = 3'd1;
	localparam logic [2:0] ST_DIV   = 3'd2;
	localparam logic [2:0] ST_EVAL  = 3'd3;
	localparam logic [2:0] ST_EMIT  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (sts.n_small || sts.full) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end else if (sts.sq_gt_n) begin
					state_d = ST_EMIT;
				end else begin
					cmd.start_div = 1'b1;
					state_d       = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.last_bit) begin
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				if (sts.rem_zero) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end else begin
					cmd.next_div = 1'b1;
					state_d      = ST_CHECK;
				end
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit   = 1'b1;
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall = (state_q != ST_IDLE);

	// evaluation always follows the last division bit
	a_eval_after_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EVAL) |-> ($past(state_q) == ST_DIV && $past(sts.last_bit)))
		else $error("eval entered without a finished remainder");

	// a new word is taken only from idle
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (state_q == ST_CHECK))
		else $error("load did not lead to check");

endmodule

[design/pftd_datapath.sv]
// datapath for the trial-division prime filter: value, divisor, square,
// bit-serial remainder unit, prime count and output register; uses pftd_pkg
module pftd_datapath #(
	parameter int VALUE_WIDTH = pftd_pkg::VALUE_WIDTH_DEF,
	parameter int DEST_DEPTH  = pftd_pkg::DEST_DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [pftd_pkg::NUM_W-1:0]  number_in,
	input  logic                        last_of_set,
	input  pftd_pkg::cmd_t              cmd,
	output pftd_pkg::sts_t              sts,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [pftd_pkg::NUM_W-1:0]  prime_value,
	output logic [pftd_pkg::SLOT_W-1:0] slot_index
);
	import pftd_pkg::*;

	// effective value width, square width, counter widths
	localparam int DW  = (VALUE_WIDTH < NUM_W) ? VALUE_WIDTH : NUM_W;
	localparam int SQW = DW + 2;
	localparam int CW  = $clog2(DEST_DEPTH + 1);
	localparam int BCW = $clog2(DW);

	logic [DW-1:0]      n_q;
	logic               last_q;
	logic [DW-1:0]      d_q;
	logic [SQW-1:0]     sq_q;
	logic [DW-1:0]      rem_q;
	logic [DW-1:0]      nsh_q;
	logic [BCW-1:0]     bit_q;
	logic [CW-1:0]      cnt_q;
	logic               out_valid_q;
	logic [NUM_W-1:0]   prime_value_q;
	logic [SLOT_W-1:0]  slot_q;

	logic [DW:0]        trial;
	logic [DW:0]        diff;
	logic               ge;
	logic [DW-1:0]      rem_next;

	// one restoring-division bit
	always_comb begin
		trial    = {rem_q, nsh_q[DW-1]};
		diff     = trial - {1'b0, d_q};
		ge       = (trial >= {1'b0, d_q});
		rem_next = ge ? diff[DW-1:0] : trial[DW-1:0];
	end

	// status toward the controller
	always_comb begin
		sts.n_small  = (n_q < DW'(FIRST_DIVISOR));
		sts.full     = (cnt_q >= CW'(DEST_DEPTH));
		sts.sq_gt_n  = (sq_q > {{(SQW-DW){1'b0}}, n_q});
		sts.last_bit = (bit_q == '0);
		sts.rem_zero = (rem_q == '0);
		sts.out_free = !out_valid_q || !out_stall;
	end

	// value, divisor, square and remainder unit
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			n_q    <= number_in[DW-1:0];
			last_q <= last_of_set;
			d_q    <= DW'(FIRST_DIVISOR);
			sq_q   <= SQW'(FIRST_DIVISOR * FIRST_DIVISOR);
		end
		if (cmd.next_div) begin
			// (d+1)^2 = d^2 + 2d + 1
			d_q  <= d_q + 1'b1;
			sq_q <= sq_q + SQW'({d_q, 1'b1});
		end
		if (cmd.start_div) begin
			rem_q <= '0;
			nsh_q <= n_q;
			bit_q <= BCW'(DW - 1);
		end
		if (cmd.div_step) begin
			rem_q <= rem_next;
			nsh_q <= {nsh_q[DW-2:0], 1'b0};
			bit_q <= bit_q - 1'b1;
		end
		if (cmd.emit) begin
			prime_value_q <= NUM_W'(n_q);
			slot_q        <= SLOT_W'(cnt_q);
		end
	end

	// prime count and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.finish && last_q) begin
				cnt_q <= '0;
			end else if (cmd.emit) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign prime_value = prime_value_q;
	assign slot_index  = slot_q;

	// count saturates at the destination depth
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEST_DEPTH))
		else $error("prime count beyond destination depth");

	// a word is never written over one still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_valid_q || !out_stall))
		else $error("output word overwritten");

	// partial remainder stays below the divisor
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |=> (rem_q < d_q))
		else $error("remainder not reduced");

	// nothing is emitted once the list is full
	a_emit_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> !sts.full)
		else $error("emit with destination full");

endmodule

[design/prime_filter_trial_division.sv]
// top level of the trial-division prime filter
// depends on pftd_pkg, pftd_ctrl and pftd_datapath
//
// Passes on only the prime numbers of an input stream, each with its slot in
// the destination list (the running prime count, which clears after a word
// marked last_of_set and saturates at DEST_DEPTH, extra primes being dropped).
// One word is worked on at a time. A value below 2, or any word while the list
// is full, is closed from the check state with no division tried. Otherwise
// divisors d = 2, 3, ... are tried while d*d <= n, each through the
// one-bit-per-cycle remainder unit over W bits, W being VALUE_WIDTH capped at
// the 16-bit port width. A prime is sent on after k divisors are tried
// (k <= sqrt(n) - 1), a non-prime is dropped at its first divisor that leaves
// no remainder. A found prime waits in the output register, and the next word
// is taken while it waits; the next prime is held back until that word has
// been taken.
module prime_filter_trial_division #(
	parameter int VALUE_WIDTH = pftd_pkg::VALUE_WIDTH_DEF,
	parameter int DEST_DEPTH  = pftd_pkg::DEST_DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [pftd_pkg::NUM_W-1:0]  number_in,
	input  logic                        last_of_set,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [pftd_pkg::NUM_W-1:0]  prime_value,
	output logic [pftd_pkg::SLOT_W-1:0] slot_index
);
	import pftd_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// sequencer
	pftd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// divisor, remainder unit, count and output register
	pftd_datapath #(
		.VALUE_WIDTH (VALUE_WIDTH),
		.DEST_DEPTH  (DEST_DEPTH)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.number_in   (number_in),
		.last_of_set (last_of_set),
		.cmd         (cmd),
		.sts         (sts),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.prime_value (prime_value),
		.slot_index  (slot_index)
	);

endmodule

[bench/tb_top.sv]
// self-checking bench for prime_filter_trial_division: directed words, random sets
// of words, and one long set that fills the destination list; depends on pftd_pkg
module tb_top;
	import pftd_pkg::*;

	localparam int VALUE_W      = VALUE_WIDTH_DEF;
	localparam int DEPTH        = DEST_DEPTH_DEF;
	localparam int CYCLE_LIMIT  = 4_000_000;
	localparam int SETTLE_CYCLES = 5000;

	// directed words: zero and one, two and three, squares of primes, field extremes,
	// last of set with and without a prime, a set of a single word
	localparam int DIR_N = 21;
	localparam logic [NUM_W-1:0] DIR_NUM [DIR_N] = '{
		16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd9, 16'd25, 16'd121,
		16'd65535, 16'd65521, 16'd32768, 16'd7, 16'd8, 16'd11, 16'd8, 16'd13,
		16'd1, 16'd169, 16'd65025, 16'd17
	};
	localparam bit DIR_LAST [DIR_N] = '{
		1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
		1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1,
		1'b1, 1'b0, 1'b0, 1'b1
	};

	logic                clk;
	logic                arst_n      = 1'b0;
	logic                in_valid    = 1'b0;
	logic                in_stall;
	logic [NUM_W-1:0]    number_in   = '0;
	logic                last_of_set = 1'b0;
	logic                out_valid;
	logic                out_stall   = 1'b0;
	logic [NUM_W-1:0]    prime_value;
	logic [SLOT_W-1:0]   slot_index;

	int snd_idle = 33;
	int rcv_idle = 85;
	int cycles   = 0;

	typedef struct {
		logic [NUM_W-1:0]  value;
		logic [SLOT_W-1:0] slot;
	} prime_word_t;

	// tracks the prime count and the primes still owed by the block
	class prime_scoreboard;
		int unsigned prime_count = 0;
		prime_word_t due_q[$];
		int errors = 0;

		static function bit is_prime(int unsigned n);
			if (n < FIRST_DIVISOR)
				return 1'b0;
			for (int unsigned d = FIRST_DIVISOR; d <= n / 2; d++)
				if (n % d == 0)
					return 1'b0;
			return 1'b1;
		endfunction

		function void note_word(logic [NUM_W-1:0] num, logic last);
			logic [NUM_W-1:0] n;
			prime_word_t      w;
			n = num & NUM_W'((64'd1 << VALUE_W) - 1);
			// primes past a full list are dropped
			if (is_prime(n) && prime_count < DEPTH) begin
				w.value = n;
				w.slot  = SLOT_W'(prime_count);
				due_q.push_back(w);
				prime_count++;
			end
			if (last)
				prime_count = 0;
		endfunction

		function void check_word(logic [NUM_W-1:0] value, logic [SLOT_W-1:0] slot);
			prime_word_t w;
			if (due_q.size() == 0) begin
				$display("%0t unexpected word: prime_value %0d slot_index %0d",
					$time, value, slot);
				errors++;
				return;
			end
			w = due_q.pop_front();
			if (value !== w.value) begin
				$display("%0t prime_value mismatch: expected %0d actual %0d",
					$time, w.value, value);
				errors++;
			end
			if (slot !== w.slot) begin
				$display("%0t slot_index mismatch: expected %0d actual %0d",
					$time, w.slot, slot);
				errors++;
			end
		endfunction

		function int pending();
			return due_q.size();
		endfunction
	endclass

	prime_scoreboard sb;

	prime_filter_trial_division #(
		.VALUE_WIDTH(VALUE_W),
		.DEST_DEPTH (DEPTH)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.number_in  (number_in),
		.last_of_set(last_of_set),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.prime_value(prime_value),
		.slot_index (slot_index)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watch both channels at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				sb.note_word(number_in, last_of_set);
			if (out_valid && !out_stall)
				sb.check_word(prime_value, slot_index);
		end
	end

	// receiver stalls at random
	always @(negedge clk)
		out_stall <= ($urandom_range(99) < rcv_idle);

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	function automatic logic [NUM_W-1:0] pick_prime(int unsigned hi);
		logic [NUM_W-1:0] n;
		do
			n = NUM_W'($urandom_range(hi, 2));
		while (!prime_scoreboard::is_prime(n));
		return n;
	endfunction

	// mostly small numbers, since large primes take long to check
	function automatic logic [NUM_W-1:0] random_number();
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 55)
			return NUM_W'($urandom_range(255));
		if (pick < 75)
			return NUM_W'($urandom_range(4095));
		if (pick < 90)
			return pick_prime(1000);
		return NUM_W'($urandom_range(65535));
	endfunction

	// present one word and hold it until taken; returns at a falling edge
	task automatic send_word(input logic [NUM_W-1:0] n, input logic last);
		while ($urandom_range(99) < snd_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid    <= 1'b1;
		number_in   <= n;
		last_of_set <= last;
		do
			@(posedge clk);
		while (in_stall);
		@(negedge clk);
	endtask

	// hold off until every owed prime has come out
	task automatic drain();
		in_valid <= 1'b0;
		do
			@(negedge clk);
		while (sb.pending() != 0);
	endtask

	// sets of random length, each closed by last_of_set, count words in all
	task automatic send_random_sets(input int count);
		int sent;
		int len;
		sent = 0;
		while (sent < count) begin
			len = $urandom_range(12, 1);
			if (len > count - sent)
				len = count - sent;
			for (int i = 0; i < len; i++) begin
				if ($urandom_range(19) == 0)
					drain();
				send_word(random_number(), i == len - 1);
			end
			sent += len;
		end
	endtask

	// one long set of primes that fills the list and drops one more,
	// then a non-prime and a dropped prime as last
	task automatic fill_destination();
		for (int i = 0; i < DEPTH + 1; i++) begin
			if ($urandom_range(49) == 0)
				send_word(pick_prime(65535), 1'b0);
			else
				send_word(pick_prime(1000), 1'b0);
		end
		send_word(16'd91, 1'b0);
		send_word(pick_prime(1000), 1'b1);
	endtask

	initial begin
		sb = new;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed words: sender idles often, receiver mostly stalls
		for (int i = 0; i < DIR_N; i++)
			send_word(DIR_NUM[i], DIR_LAST[i]);
		drain();

		// sender mostly idles, receiver stalls now and then
		snd_idle = 85;
		rcv_idle = 33;
		send_random_sets(8);
		drain();

		// no idling on either side; fill the list, then check the count clears
		snd_idle = 0;
		rcv_idle = 0;
		fill_destination();
		send_random_sets(4);
		drain();

		repeat (SETTLE_CYCLES) @(negedge clk);
		if (sb.errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

[filelist.f]
design/pftd_pkg.sv
design/pftd_ctrl.sv
design/pftd_datapath.sv
design/prime_filter_trial_division.sv
bench/tb_top.sv
